FILE: src/srsa_pkg.sv
// Package for the sparse row slot accumulator: constants, codes and state type.
`default_nettype none
package srsa_pkg;
	localparam int ROW_COUNT_DEF     = 256;
	localparam int SLOTS_PER_ROW_DEF = 16;
	localparam int ROWS_W            = 9;
	localparam int TAG_W             = 16;
	localparam int COL_W             = 16;
	localparam int VAL_W             = 32;
	localparam int STAT_W            = 3;
	localparam int ACT_W             = 2;
	localparam int ROW_IN_W          = 8;
	localparam int LIM_W             = 18;
	localparam int SLOT_W            = TAG_W + COL_W + VAL_W;

	localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(256);

	localparam logic [STAT_W-1:0] STAT_UPDATED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_BAD_ROW  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd4;

	localparam logic [ACT_W-1:0] ACT_ADD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_SET = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_COUNT, ST_DRAIN, ST_EMPTY, ST_SCAN,
		ST_INS, ST_SHIFT, ST_PLACE, ST_FULL
	} state_t;

	// saturating Q16.16 add
	function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
		input logic [VAL_W-1:0] b);
		logic [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s[VAL_W] != s[VAL_W-1])
			return s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		return s[VAL_W-1:0];
	endfunction
endpackage
`default_nettype wire

FILE: src/sparse_row_slot_accumulator.sv
// Path from input transfer to launch: bad row launches from CHECK; update passes
// CHECK, COUNT, SCAN per slot; insert adds INS, SHIFT per shifted slot, PLACE;
// full row INS, FULL. Drain: one entry per cycle unless held; empty drain: EMPTY.
// One item at a time, input ready again the cycle after the last result launches;
// a held result stalls the launch. Reset: per-row valid bits clear at once so every
// row reads empty; rows_in_use returns to 256. Slot contents undefined until written.
`default_nettype none
module sparse_row_slot_accumulator
	import srsa_pkg::*;
#(
	parameter int ROW_COUNT     = ROW_COUNT_DEF,
	parameter int SLOTS_PER_ROW = SLOTS_PER_ROW_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [ROWS_W-1:0] cfg_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [71:0]       s_tdata,  // local_row, global_row, column, value
	input  wire logic [ACT_W-1:0]  s_tuser,  // action
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata,  // out_row_tag, out_column, out_value
	output logic [STAT_W-1:0]      m_tuser,  // status
	output logic                   m_tlast   // last
);
	localparam int DEPTH  = ROW_COUNT * SLOTS_PER_ROW;
	localparam int ADDR_W = DEPTH > 1 ? $clog2(DEPTH) : 1;
	localparam int ROW_W  = ROW_COUNT > 1 ? $clog2(ROW_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOTS_PER_ROW + 1);

	state_t state_q, state_d;
	logic [ROWS_W-1:0]   rows_q;
	logic [ACT_W-1:0]    act_q;
	logic [ROW_IN_W-1:0] row_q;
	logic [TAG_W-1:0]    tag_q;
	logic [COL_W-1:0]    col_q;
	logic [VAL_W-1:0]    val_q;
	logic [CNT_W-1:0]    n_q, i_q, p_q, k_q;
	logic [ROW_COUNT-1:0] row_valid_q;

	logic [ROW_W-1:0]  row_idx;
	logic [LIM_W-1:0]  limit;
	logic              bad_row, out_free, s_xfer;
	logic [CNT_W-1:0]  n_now;

	// RAM ports
	logic              slot_we, slot_re, cnt_we;
	logic [ADDR_W-1:0] slot_waddr, slot_raddr;
	logic [SLOT_W-1:0] slot_wdata, slot_rdata;
	logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
	logic [TAG_W-1:0]  rd_tag;
	logic [COL_W-1:0]  rd_col;
	logic [VAL_W-1:0]  rd_val;

	// result launch
	logic              emit;
	logic [STAT_W-1:0] e_stat;
	logic [TAG_W-1:0]  e_tag;
	logic [COL_W-1:0]  e_col;
	logic [VAL_W-1:0]  e_val;
	logic              e_last;

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [ROW_W-1:0] r,
		input logic [CNT_W-1:0] s);
		return ADDR_W'(int'(r) * SLOTS_PER_ROW + int'(s));
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_xfer    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign row_idx   = ROW_W'(row_q);
	assign limit     = (LIM_W'(rows_q) > LIM_W'(ROW_COUNT)) ? LIM_W'(ROW_COUNT)
	                                                        : LIM_W'(rows_q);
	assign bad_row   = LIM_W'(row_q) >= limit;
	assign n_now     = row_valid_q[row_idx] ? cnt_rdata : '0;
	assign {rd_val, rd_col, rd_tag} = slot_rdata;

	srsa_ram #(.WIDTH(SLOT_W), .DEPTH(DEPTH)) u_slot_ram (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(slot_re), .raddr(slot_raddr), .rdata(slot_rdata)
	);

	srsa_ram #(.WIDTH(CNT_W), .DEPTH(ROW_COUNT)) u_count_ram (
		.clk(clk), .we(cnt_we), .waddr(row_idx), .wdata(cnt_wdata),
		.re(state_q == ST_CHECK), .raddr(row_idx), .rdata(cnt_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_xfer) state_d = ST_CHECK;
			ST_CHECK: begin
				if (!bad_row) state_d = ST_COUNT;
				else if (out_free) state_d = ST_IDLE;
			end
			ST_COUNT: begin
				if (act_q[1]) state_d = (n_now == '0) ? ST_EMPTY : ST_DRAIN;
				else state_d = (n_now == '0) ? ST_INS : ST_SCAN;
			end
			ST_DRAIN: if (out_free && i_q + 1'b1 == n_q) state_d = ST_IDLE;
			ST_EMPTY, ST_FULL, ST_PLACE: if (out_free) state_d = ST_IDLE;
			ST_SCAN: begin
				if (rd_col == col_q) begin
					if (out_free) state_d = ST_IDLE;
				end else if (rd_col > col_q || i_q + 1'b1 == n_q) begin
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (n_q == CNT_W'(SLOTS_PER_ROW)) state_d = ST_FULL;
				else if (n_q > p_q) state_d = ST_SHIFT;
				else state_d = ST_PLACE;
			end
			ST_SHIFT: if (k_q - 1'b1 == p_q) state_d = ST_PLACE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory accesses and result launch
	always_comb begin
		slot_we = 1'b0; slot_re = 1'b0; cnt_we = 1'b0;
		slot_waddr = slot_addr(row_idx, i_q);
		slot_raddr = slot_addr(row_idx, '0);
		slot_wdata = {rd_val, rd_col, rd_tag};
		cnt_wdata  = n_q + 1'b1;
		emit = 1'b0; e_stat = STAT_UPDATED; e_tag = '0; e_col = '0; e_val = '0;
		e_last = 1'b1;
		unique case (state_q)
			ST_CHECK: if (bad_row) begin
				emit = out_free; e_stat = STAT_BAD_ROW; e_tag = tag_q; e_col = col_q;
			end
			ST_COUNT: slot_re = (n_now != '0);
			ST_DRAIN: begin
				emit = out_free; e_tag = rd_tag; e_col = rd_col; e_val = rd_val;
				e_last = (i_q + 1'b1 == n_q);
				slot_re = out_free && !e_last;
				slot_raddr = slot_addr(row_idx, i_q + 1'b1);
			end
			ST_EMPTY: begin
				emit = out_free; e_stat = STAT_EMPTY;
			end
			ST_SCAN: begin
				if (rd_col == col_q) begin
					emit = out_free; slot_we = out_free;
					e_tag = rd_tag; e_col = col_q;
					e_val = (act_q == ACT_ADD) ? sat_add(rd_val, val_q) : val_q;
					slot_wdata = {e_val, rd_col, rd_tag};
				end else if (!(rd_col > col_q) && i_q + 1'b1 != n_q) begin
					slot_re = 1'b1;
					slot_raddr = slot_addr(row_idx, i_q + 1'b1);
				end
			end
			ST_INS: if (n_q != CNT_W'(SLOTS_PER_ROW) && n_q > p_q) begin
				slot_re = 1'b1;
				slot_raddr = slot_addr(row_idx, n_q - 1'b1);
			end
			ST_SHIFT: begin
				slot_we = 1'b1;
				slot_waddr = slot_addr(row_idx, k_q);
				slot_re = (k_q - 1'b1 != p_q);
				slot_raddr = slot_addr(row_idx, k_q - 2'd2);
			end
			ST_PLACE: begin
				emit = out_free; slot_we = out_free; cnt_we = out_free;
				slot_waddr = slot_addr(row_idx, p_q);
				slot_wdata = {val_q, col_q, tag_q};
				e_stat = STAT_INSERTED; e_tag = tag_q; e_col = col_q; e_val = val_q;
			end
			ST_FULL: begin
				emit = out_free; e_stat = STAT_FULL; e_tag = tag_q; e_col = col_q;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= ROWS_RESET;
			row_valid_q <= '0;
			m_tvalid    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready)
				rows_q <= cfg_data;
			if (cnt_we)
				row_valid_q[row_idx] <= 1'b1;
			if (emit)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	// item fields, slot indexes and output payload
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			act_q <= s_tuser;
			row_q <= s_tdata[7:0];
			tag_q <= s_tdata[23:8];
			col_q <= s_tdata[39:24];
			val_q <= s_tdata[71:40];
		end
		if (state_q == ST_COUNT) begin
			n_q <= n_now;
			i_q <= '0;
			p_q <= '0;
		end
		if (state_q == ST_DRAIN && out_free)
			i_q <= i_q + 1'b1;
		if (state_q == ST_SCAN && rd_col != col_q) begin
			if (rd_col > col_q) p_q <= i_q;
			else if (i_q + 1'b1 == n_q) p_q <= n_q;
			i_q <= i_q + 1'b1;
		end
		if (state_q == ST_INS)
			k_q <= n_q;
		if (state_q == ST_SHIFT)
			k_q <= k_q - 1'b1;
		if (emit) begin
			m_tdata <= {e_val, e_col, e_tag};
			m_tuser <= e_stat;
			m_tlast <= e_last;
		end
	end

	// checks
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit && m_tvalid |-> m_tready) else $error("result launched over a held one");
	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SHIFT |-> k_q > p_q && k_q <= CNT_W'(SLOTS_PER_ROW))
		else $error("shift index out of range");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> cnt_wdata <= CNT_W'(SLOTS_PER_ROW)) else $error("row count overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> !s_tready) else $error("second item taken while busy");
endmodule
`default_nettype wire

FILE: src/srsa_ram.sv
// Generic simple dual port RAM, one write port, one registered read port.
`default_nettype none
module srsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: sim/srsa_checker.sv
// Checker for the sparse row slot accumulator: predicts results and compares transfers.
`timescale 1ns / 100ps
module srsa_checker
	import srsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	input  wire logic              cfg_ready,
	input  wire logic [ROWS_W-1:0] cfg_data,
	input  wire logic              s_tvalid,
	input  wire logic              s_tready,
	input  wire logic [71:0]       s_tdata,  // local_row, global_row, column, value
	input  wire logic [ACT_W-1:0]  s_tuser,  // action
	input  wire logic              m_tvalid,
	input  wire logic              m_tready,
	input  wire logic [63:0]       m_tdata,  // out_row_tag, out_column, out_value
	input  wire logic [STAT_W-1:0] m_tuser,  // status
	input  wire logic              m_tlast,
	output int                     fails,
	output int                     pending,
	output int                     items_seen,
	output int                     results_seen
);
	typedef struct packed {
		logic [STAT_W-1:0] stat;
		logic [TAG_W-1:0]  tag;
		logic [COL_W-1:0]  col;
		logic [VAL_W-1:0]  val;
		logic              last;
	} entry_result_t;

	entry_result_t expected_q[$];

	// shadow copy of the slot store; used slots are packed at the front of a row
	int                row_fill [ROW_COUNT_DEF];
	logic [COL_W-1:0]  sh_col   [ROW_COUNT_DEF][SLOTS_PER_ROW_DEF];
	logic [TAG_W-1:0]  sh_tag   [ROW_COUNT_DEF][SLOTS_PER_ROW_DEF];
	logic [VAL_W-1:0]  sh_val   [ROW_COUNT_DEF][SLOTS_PER_ROW_DEF];
	logic [ROWS_W-1:0] rows_cfg;

	assign pending = expected_q.size();

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, results_seen);
		fails++;
	endtask

	function automatic entry_result_t mk(logic [STAT_W-1:0] s, logic [TAG_W-1:0] t,
		logic [COL_W-1:0] c, logic [VAL_W-1:0] v, logic l);
		entry_result_t r;
		r.stat = s; r.tag = t; r.col = c; r.val = v; r.last = l;
		return r;
	endfunction

	function automatic logic [VAL_W-1:0] clamp_sum(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
		longint s;
		s = longint'($signed(a)) + longint'($signed(b));
		if (s > 64'sd2147483647) return 32'h7fff_ffff;
		if (s < -64'sd2147483648) return 32'h8000_0000;
		return s[31:0];
	endfunction

	// work out the results of one accepted item and update the shadow store
	task automatic predict_item(logic [ACT_W-1:0] act, logic [71:0] d);
		logic [7:0]        row;
		logic [TAG_W-1:0]  gtag;
		logic [COL_W-1:0]  col;
		logic [VAL_W-1:0]  val;
		int                lim, n, p;
		row  = d[7:0];
		gtag = d[23:8];
		col  = d[39:24];
		val  = d[71:40];
		lim  = (rows_cfg > ROW_COUNT_DEF) ? ROW_COUNT_DEF : int'(rows_cfg);
		if (int'(row) >= lim) begin
			expected_q.push_back(mk(STAT_BAD_ROW, gtag, col, '0, 1'b1));
			return;
		end
		n = row_fill[row];
		if (act != ACT_ADD && act != ACT_SET) begin
			if (n == 0) begin
				expected_q.push_back(mk(STAT_EMPTY, '0, '0, '0, 1'b1));
			end else begin
				for (int i = 0; i < n; i++)
					expected_q.push_back(mk(STAT_UPDATED, sh_tag[row][i], sh_col[row][i],
						sh_val[row][i], i == n - 1));
			end
			return;
		end
		for (int i = 0; i < n; i++) begin
			if (sh_col[row][i] == col) begin
				sh_val[row][i] = (act == ACT_ADD) ? clamp_sum(sh_val[row][i], val) : val;
				expected_q.push_back(mk(STAT_UPDATED, sh_tag[row][i], col, sh_val[row][i], 1'b1));
				return;
			end
		end
		if (n >= SLOTS_PER_ROW_DEF) begin
			expected_q.push_back(mk(STAT_FULL, gtag, col, '0, 1'b1));
			return;
		end
		p = 0;
		while (p < n && sh_col[row][p] < col) p++;
		for (int i = n; i > p; i--) begin
			sh_col[row][i] = sh_col[row][i-1];
			sh_tag[row][i] = sh_tag[row][i-1];
			sh_val[row][i] = sh_val[row][i-1];
		end
		sh_col[row][p] = col;
		sh_tag[row][p] = gtag;
		sh_val[row][p] = val;
		row_fill[row]  = n + 1;
		expected_q.push_back(mk(STAT_INSERTED, gtag, col, val, 1'b1));
	endtask

	initial begin
		fails = 0;
		items_seen = 0;
		results_seen = 0;
		rows_cfg = ROWS_RESET;
		foreach (row_fill[i]) row_fill[i] = 0;
	end

	// sample every channel at the clock edge
	always @(posedge clk) begin
		entry_result_t w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) rows_cfg = cfg_data;
			if (s_tvalid && s_tready) begin
				predict_item(s_tuser, s_tdata);
				items_seen++;
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result status", 32'(m_tuser), 32'(0));
				end else begin
					w = expected_q.pop_front();
					if (m_tuser != w.stat) report_mismatch("status", 32'(m_tuser), 32'(w.stat));
					if (m_tdata[15:0] != w.tag) report_mismatch("row_tag", 32'(m_tdata[15:0]), 32'(w.tag));
					if (m_tdata[31:16] != w.col) report_mismatch("column", 32'(m_tdata[31:16]), 32'(w.col));
					if (m_tdata[63:32] != w.val) report_mismatch("value", m_tdata[63:32], w.val);
					if (m_tlast != w.last) report_mismatch("last", 32'(m_tlast), 32'(w.last));
				end
			end
		end
	end
endmodule

FILE: sim/tb_sparse_row_slot_accumulator.sv
// Testbench top for the sparse row slot accumulator: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_sparse_row_slot_accumulator;
	import srsa_pkg::*;

	localparam logic [ACT_W-1:0] ACT_DRAIN = 2'd2;
	localparam logic [ACT_W-1:0] ACT_ALT_DRAIN = 2'd3;
	localparam int RANDOM_ITEMS = 250;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [ROWS_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [71:0]       s_tdata = '0;  // local_row, global_row, column, value
	logic [ACT_W-1:0]  s_tuser = '0;  // action
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [63:0]       m_tdata;       // out_row_tag, out_column, out_value
	logic [STAT_W-1:0] m_tuser;       // status
	logic              m_tlast;

	int fails, pending, items_seen, results_seen;
	int send_idle = 0;
	int recv_idle = 0;

	sparse_row_slot_accumulator DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	srsa_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fails(fails), .pending(pending), .items_seen(items_seen), .results_seen(results_seen)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver stalls
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(logic [ACT_W-1:0] act, logic [7:0] row, logic [15:0] gtag,
		logic [15:0] col, logic [31:0] val);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {val, col, gtag, row};
		do @(posedge clk); while (!s_tready);
	endtask

	// drain outstanding results, then let the block settle before a write
	task automatic write_rows(logic [ROWS_W-1:0] v);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [ROWS_W-1:0] phase_rows [6] = '{9'd8, 9'd0, 9'd300, 9'd1, 9'd511, 9'd256};
		logic [ACT_W-1:0]  act;
		logic [7:0]        row;
		logic [15:0]       col;
		int                pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: saturation, set, ordering, empty drain, alternate drain code
		send_item(ACT_ADD, 8'd0, 16'h1234, 16'd100, 32'h7fff_0000);
		send_item(ACT_ADD, 8'd0, 16'hffff, 16'd100, 32'h7fff_0000);
		send_item(ACT_SET, 8'd0, 16'h0000, 16'd100, 32'h8000_0000);
		send_item(ACT_ADD, 8'd0, 16'h0000, 16'd100, 32'hffff_ffff);
		send_item(ACT_SET, 8'd0, 16'hffff, 16'd0, 32'h0000_0001);
		send_item(ACT_ADD, 8'd0, 16'h5555, 16'hffff, 32'h7fff_ffff);
		send_item(ACT_DRAIN, 8'd0, 16'h0, 16'h0, 32'h0);
		send_item(ACT_ALT_DRAIN, 8'd1, 16'hffff, 16'hffff, 32'hffff_ffff);
		send_item(ACT_ADD, 8'd255, 16'haaaa, 16'd7, 32'h0001_0000);
		// fill a row in falling column order so every insert after the first shifts, then overflow it
		for (int i = 0; i < 16; i++)
			send_item(ACT_SET, 8'd2, 16'(i), 16'(1000 - 50 * i), 32'(i * 65536));
		send_item(ACT_ADD, 8'd2, 16'hbeef, 16'd1, 32'h1);
		send_item(ACT_DRAIN, 8'd2, 16'h0, 16'h0, 32'h0);
		write_rows(9'd100);
		send_item(ACT_ADD, 8'd100, 16'h0f0f, 16'd3, 32'h1);
		send_item(ACT_ALT_DRAIN, 8'd255, 16'h0, 16'h0, 32'h0);

		// random phases: mostly a few hot rows and a small column pool
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 47 == 0) write_rows(phase_rows[i / 47]);
			case (i * 3 / RANDOM_ITEMS)
				0: begin send_idle = 17; recv_idle = 47; end
				1: begin send_idle = 47; recv_idle = 17; end
				default: begin send_idle = 0; recv_idle = 0; end
			endcase
			pick = $urandom_range(99);
			act  = (pick < 40) ? ACT_ADD : (pick < 65) ? ACT_SET :
				(pick < 90) ? ACT_DRAIN : ACT_ALT_DRAIN;
			row  = ($urandom_range(9) < 7) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
			col  = ($urandom_range(9) < 8) ? 16'($urandom_range(24)) : 16'($urandom);
			send_item(act, row, 16'($urandom), col, $urandom);
		end
		s_tvalid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		$display("covered %0d items and %0d results over several row limits,", items_seen,
			results_seen);
		$display("with saturation, shifting inserts, full rows, bad rows and empty drains");
		if (fails == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end
endmodule

FILE: sim.f
src/srsa_pkg.sv
src/srsa_ram.sv
src/sparse_row_slot_accumulator.sv
sim/srsa_checker.sv
sim/tb_sparse_row_slot_accumulator.sv
